>>> sv/tpad_pkg.sv
// Shared types and constants for the TRIAC phase-angle heater drive.
// No dependencies; the top level imports this package.
`default_nettype none

package tpad_pkg;

  // Register indexes of the configuration port
  typedef enum logic [1:0] {
    REG_POWER      = 2'd0,
    REG_HALF_CYCLE = 2'd1,
    REG_GATE_PULSE = 2'd2
  } cfg_reg_e;

  localparam int POWER_W = 7;
  localparam int HALF_W  = 14;
  localparam int PULSE_W = 10;
  localparam int CFG_W   = 14;
  localparam int PROD_W  = HALF_W + POWER_W;

  localparam logic [HALF_W-1:0]  HALF_CYCLE_RESET = 14'd8333;
  localparam logic [PULSE_W-1:0] GATE_PULSE_RESET = 10'd50;
  localparam logic [POWER_W-1:0] FULL_LEVEL       = 7'd100;
  localparam logic [POWER_W-1:0] HALF_LEVEL       = 7'd50;
  localparam logic [POWER_W-1:0] FULL_LEVEL_DELAY = 7'd100;

  // floor(x / 100) == (x * RECIP_MUL) >> RECIP_SHIFT for every x below 2^21
  localparam int               RECIP_W     = 22;
  localparam int               RECIP_SHIFT = 28;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 22'd2684355;

  typedef struct packed {
    logic zero_cross;
  } tick_item_t;

  typedef struct packed {
    logic triac_gate;
    logic relay_drive;
    logic heating_active;
  } drive_item_t;

endpackage

`default_nettype wire

>>> sv/tpad_stream_if.sv
// Valid/ready channel carrying one item of a chosen payload type.
// Used with the item types of tpad_pkg.
`default_nettype none

interface tpad_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/triac_phase_angle_heater_drive_top.sv
// Top level of the TRIAC phase-angle heater drive with bypass relay.
// Depends on tpad_pkg and tpad_stream_if.
`default_nettype none

// One item per microsecond tick goes in on tick, one result per tick comes out
// on drive, at a sustained rate of one item per clock cycle outside a delay
// recompute: the pulse and phase counters advance by one tick in a single pass
// of logic between the input handshake and the result register. The result
// register frees as it is taken, so items flow back to back while the sink
// keeps ready high. A write to the power or half-cycle register recomputes the
// phase delay in a two-stage multiply-by-reciprocal pipeline; tick.ready is low
// while it runs, so the next tick always sees the new delay. Power above 100 in
// the low seven bits of cfg_data saturates to 100; a write of zero power drops
// any gate pulse in progress, while a countdown already running still fires.
// Register indexes beyond the gate pulse register are ignored. COUNTER_BITS
// sets the phase counter width; delays that do not fit saturate to the maximum.
module triac_phase_angle_heater_drive_top #(
  parameter int COUNTER_BITS = 14
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  tpad_stream_if.sink               tick,
  tpad_stream_if.source             drive,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [tpad_pkg::CFG_W-1:0] cfg_data
);
  import tpad_pkg::*;

  localparam int CMP_W = (COUNTER_BITS > HALF_W) ? COUNTER_BITS : HALF_W;
  localparam logic [COUNTER_BITS-1:0] COUNT_MAX = {COUNTER_BITS{1'b1}};
  localparam logic [1:0] DLY_STAGES = 2'd2;

  // Configuration registers
  logic [POWER_W-1:0] power_percent;
  logic [HALF_W-1:0]  half_cycle_ticks;
  logic [PULSE_W-1:0] gate_pulse_ticks;

  // Tick state
  logic [COUNTER_BITS-1:0] fire_delay;
  logic [COUNTER_BITS-1:0] phase_remaining;
  logic                    phase_pending;
  logic [PULSE_W-1:0]      pulse_remaining;
  logic                    gate_level;

  // Delay recompute pipeline
  logic [1:0]         dly_busy;
  logic [PROD_W-1:0]  dly_prod;
  logic               dly_zero;
  logic               dly_full;

  // Result register
  logic        out_valid;
  drive_item_t out_data;

  logic accept;
  assign tick.ready  = !rst && (dly_busy == 2'd0) && (!out_valid || drive.ready);
  assign accept      = tick.valid && tick.ready;
  assign drive.valid = out_valid;
  assign drive.data  = out_data;

  // Config write decode
  logic [POWER_W-1:0] power_sat;
  assign power_sat = (cfg_data[POWER_W-1:0] > FULL_LEVEL) ? FULL_LEVEL
                                                           : cfg_data[POWER_W-1:0];

  logic wr_power, wr_half, wr_pulse;
  always_comb begin
    wr_power = 1'b0;
    wr_half  = 1'b0;
    wr_pulse = 1'b0;
    case (cfg_index)
      REG_POWER:      wr_power = cfg_we;
      REG_HALF_CYCLE: wr_half  = cfg_we;
      REG_GATE_PULSE: wr_pulse = cfg_we;
      default: ;
    endcase
  end

  // Stage one: TRIAC level and half_cycle * (100 - level)
  logic [POWER_W-1:0] level;
  logic [POWER_W-1:0] level_gap;
  always_comb begin
    if (power_percent == '0) begin
      level = '0;
    end else if (power_percent <= HALF_LEVEL) begin
      level = {power_percent[POWER_W-2:0], 1'b0};
    end else begin
      level = 7'(power_percent - HALF_LEVEL) << 1;
    end
    level_gap = (level >= FULL_LEVEL) ? '0 : 7'(FULL_LEVEL - level);
  end

  // Stage two: divide by 100 through the reciprocal, then saturate
  logic [PROD_W+RECIP_W-1:0] dly_scaled;
  logic [HALF_W-1:0]         dly_quot;
  logic [COUNTER_BITS-1:0]   dly_result;
  always_comb begin
    dly_scaled = PROD_W'(dly_prod) * (PROD_W+RECIP_W)'(RECIP_MUL);
    dly_quot   = dly_scaled[RECIP_SHIFT +: HALF_W];
    if (dly_zero) begin
      dly_result = '0;
    end else if (dly_full) begin
      dly_result = COUNTER_BITS'(FULL_LEVEL_DELAY);
    end else if (CMP_W'(dly_quot) > CMP_W'(COUNT_MAX)) begin
      dly_result = COUNT_MAX;
    end else begin
      dly_result = COUNTER_BITS'(dly_quot);
    end
  end

  // One tick: pulse first, then the phase countdown, then the crossing
  logic [COUNTER_BITS-1:0] phase_remaining_next;
  logic                    phase_pending_next;
  logic [PULSE_W-1:0]      pulse_remaining_next;
  logic                    gate_level_next;
  logic [COUNTER_BITS-1:0] rem_dec;
  always_comb begin
    pulse_remaining_next = pulse_remaining;
    gate_level_next      = gate_level;
    phase_remaining_next = phase_remaining;
    phase_pending_next   = phase_pending;
    rem_dec              = '0;

    if (gate_level && pulse_remaining != '0) begin
      pulse_remaining_next = pulse_remaining - 1'b1;
      if (pulse_remaining_next == '0) begin
        gate_level_next = 1'b0;
      end
    end

    if (phase_pending) begin
      rem_dec = (phase_remaining != '0) ? phase_remaining - 1'b1 : phase_remaining;
      phase_remaining_next = rem_dec;
      if (rem_dec == '0) begin
        phase_pending_next   = 1'b0;
        gate_level_next      = 1'b1;
        pulse_remaining_next = (gate_pulse_ticks == '0) ? PULSE_W'(1) : gate_pulse_ticks;
      end
    end

    // Drop crossings while a countdown runs or when the delay is out of range
    if (tick.data.zero_cross && !phase_pending_next && fire_delay != '0 &&
        CMP_W'(fire_delay) < CMP_W'(half_cycle_ticks)) begin
      phase_pending_next   = 1'b1;
      phase_remaining_next = fire_delay;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power_percent    <= '0;
      half_cycle_ticks <= HALF_CYCLE_RESET;
      gate_pulse_ticks <= GATE_PULSE_RESET;
      fire_delay       <= '0;
      phase_remaining  <= '0;
      phase_pending    <= 1'b0;
      pulse_remaining  <= '0;
      gate_level       <= 1'b0;
      dly_busy         <= '0;
      out_valid        <= 1'b0;
    end else begin
      // Advance the tick state on each accepted item
      if (accept) begin
        phase_remaining <= phase_remaining_next;
        phase_pending   <= phase_pending_next;
        pulse_remaining <= pulse_remaining_next;
        gate_level      <= gate_level_next;
        out_valid       <= 1'b1;
      end else if (drive.ready) begin
        out_valid <= 1'b0;
      end

      // Finish the delay recompute
      if (dly_busy != 2'd0) begin
        dly_busy <= dly_busy - 1'b1;
        if (dly_busy == 2'd1) begin
          fire_delay <= dly_result;
        end
      end

      // Register writes must land only while the block is idle; the block does not enforce it
      if (wr_power) begin
        power_percent <= power_sat;
        if (power_sat == '0) begin
          gate_level      <= 1'b0;
          pulse_remaining <= '0;
        end
        dly_busy <= DLY_STAGES;
      end
      if (wr_half) begin
        half_cycle_ticks <= cfg_data[HALF_W-1:0];
        dly_busy         <= DLY_STAGES;
      end
      if (wr_pulse) begin
        gate_pulse_ticks <= cfg_data[PULSE_W-1:0];
      end
    end
  end

  // Payload registers: delay pipeline and result
  always_ff @(posedge clk) begin
    if (dly_busy == DLY_STAGES) begin
      dly_prod <= PROD_W'(half_cycle_ticks) * PROD_W'(level_gap);
      dly_zero <= (level == '0);
      dly_full <= (level >= FULL_LEVEL);
    end
    if (accept) begin
      out_data.triac_gate     <= gate_level_next;
      out_data.relay_drive    <= (power_percent > HALF_LEVEL);
      out_data.heating_active <= (power_percent != '0);
    end
  end

  // Hold off ticks while a new delay is on its way
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    (dly_busy != 2'd0) |-> !tick.ready)
    else $error("tick accepted during delay recompute");

  a_delay_write_busy: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && (cfg_index == REG_POWER || cfg_index == REG_HALF_CYCLE))
      |=> (dly_busy == DLY_STAGES))
    else $error("delay write did not start recompute");

  a_pending_count: assert property (@(posedge clk) disable iff (rst)
    phase_pending |-> (phase_remaining != '0))
    else $error("countdown pending with zero remaining");

  a_gate_pulse: assert property (@(posedge clk) disable iff (rst)
    gate_level |-> (pulse_remaining != '0))
    else $error("gate high with no pulse remaining");

endmodule

`default_nettype wire
